@@ design/esp_pkg.sv @@
package esp_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int TIMER_WIDTH_DEF = 30;

  localparam int PW_W       = 16;
  localparam int HOLD_W     = 20;
  localparam int FREQ_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int OUT_DATA_W = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ    = 2'd2;

  localparam logic [PW_W-1:0]   PULSE_WIDTH_RST = 16'd100;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST     = 20'd100000;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST    = 21'd1024000;

  // The count step is clamped to +-127 so that its cube stays exact.
  localparam int STEP_W   = 8;
  localparam int SQ_W     = 16;
  localparam int CUBE_W   = 24;
  localparam int SUM_W    = 25;
  localparam int STEP_LIM = 127;

  // Period numerator: one second in ticks times 512.
  localparam int NUM_W = 29;
  localparam logic [NUM_W-1:0] PERIOD_NUMERATOR = 29'd512000000;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PW_W-1:0]   pulse_width;
    logic [HOLD_W-1:0] holdoff;
    logic [FREQ_W-1:0] max_freq;
  } esp_cfg_t;

  typedef struct packed {
    logic              adjust;
    logic [FREQ_W-1:0] freq;
  } esp_entry_t;

endpackage

@@ design/esp_front.sv @@
module esp_front import esp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COUNT_WIDTH-1:0] in_pos,
  input  esp_cfg_t               cfg,
  input  logic                   q_full,
  output logic                   push,
  output esp_entry_t             push_entry
);

  localparam int DW = COUNT_WIDTH + 1;
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_CUBE = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam logic signed [DW-1:0] LIM_HI = DW'(STEP_LIM);
  localparam logic signed [DW-1:0] LIM_LO = -DW'(STEP_LIM);

  logic [1:0]                    state;
  logic [FREQ_W-1:0]             freq;
  logic signed [COUNT_WIDTH-1:0] ref_cnt;
  logic [COUNT_WIDTH-1:0]        pos;
  logic [HOLD_W-1:0]             hold;
  logic signed [STEP_W-1:0]      step;
  logic signed [SQ_W-1:0]        sq;
  logic signed [CUBE_W-1:0]      cube;
  logic                          adj;
  logic                          neg;

  logic [HOLD_W-1:0]        hold_inc;
  logic signed [DW-1:0]     diff;
  logic signed [STEP_W-1:0] step_next;
  logic signed [SUM_W-1:0]  sum;
  logic                     bad;
  logic                     accept;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign hold_inc = (hold != '1) ? hold + 1'b1 : hold;
  assign diff     = $signed({in_pos[COUNT_WIDTH-1], in_pos})
                  - $signed({ref_cnt[COUNT_WIDTH-1], ref_cnt});

  always_comb begin
    if (diff > LIM_HI) begin
      step_next = STEP_W'(STEP_LIM);
    end else if (diff < LIM_LO) begin
      step_next = -STEP_W'(STEP_LIM);
    end else begin
      step_next = diff[STEP_W-1:0];
    end
  end

  assign sum = $signed({{(SUM_W-FREQ_W){1'b0}}, freq}) + cube;
  assign bad = sum[SUM_W-1] || neg
            || (sum > $signed({{(SUM_W-FREQ_W){1'b0}}, cfg.max_freq}));

  assign push              = (state == F_PUSH) && !q_full;
  assign push_entry.adjust = adj;
  assign push_entry.freq   = !adj ? freq : (bad ? '0 : sum[FREQ_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      freq    <= '0;
      ref_cnt <= '0;
      hold    <= '0;
      adj     <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            hold  <= hold_inc;
            adj   <= ($signed(in_pos) != ref_cnt) && (hold_inc > cfg.holdoff);
            state <= F_SQ;
          end
        end
        F_SQ:   state <= F_CUBE;
        F_CUBE: state <= F_PUSH;
        F_PUSH: begin
          if (push) begin
            if (adj) begin
              hold <= '0;
              if (bad) begin
                freq    <= '0;
                ref_cnt <= '0;
              end else begin
                freq    <= sum[FREQ_W-1:0];
                ref_cnt <= $signed(pos);
              end
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath registers: the cube is built over two multiplier stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos  <= in_pos;
      step <= step_next;
      neg  <= in_pos[COUNT_WIDTH-1];
    end
    if (state == F_SQ) begin
      sq <= step * step;
    end
    if (state == F_CUBE) begin
      cube <= sq * step;
    end
  end

endmodule

@@ design/esp_queue.sv @@
module esp_queue import esp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  esp_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output esp_entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  esp_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign valid     = (count != '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ design/esp_back.sv @@
module esp_back import esp_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  esp_entry_t            q_entry,
  output logic                  pop,
  input  logic [PW_W-1:0]       pulse_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_SAT  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;
  localparam int CMP_W   = (NUM_W > TIMER_WIDTH) ? NUM_W : TIMER_WIDTH;
  localparam int BIT_W   = $clog2(NUM_W);
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;
  localparam logic [CMP_W-1:0] TMAX_CMP = CMP_W'(TMAX);

  logic [1:0]             state;
  logic [FREQ_W-1:0]      freq;
  logic [TIMER_WIDTH-1:0] period;
  logic [TIMER_WIDTH-1:0] elapsed;
  logic                   active;
  logic [FREQ_W-1:0]      rem;
  logic [NUM_W-1:0]       quot;
  logic [BIT_W-1:0]       bit_idx;
  logic                   strobe;
  logic [FREQ_W-1:0]      out_freq;

  logic [FREQ_W:0]        rem_sh;
  logic                   ge;
  logic                   out_free;
  logic [TIMER_WIDTH-1:0] el_inc;
  logic [TIMER_WIDTH-1:0] el_next;
  logic                   active_next;
  logic                   lamp;

  assign pop      = (state == B_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign out_data = {{(OUT_DATA_W - FREQ_W - 1){1'b0}}, out_freq, strobe};

  // One quotient bit a cycle, most significant bit of the numerator first.
  assign rem_sh = {rem, PERIOD_NUMERATOR[bit_idx]};
  assign ge     = rem_sh >= {1'b0, freq};

  assign el_inc = (elapsed != TMAX) ? elapsed + 1'b1 : elapsed;

  always_comb begin
    if (freq == '0) begin
      active_next = 1'b0;
      el_next     = '0;
    end else if (!active) begin
      active_next = 1'b1;
      el_next     = '0;
    end else begin
      active_next = 1'b1;
      el_next     = (el_inc >= period) ? '0 : el_inc;
    end
    lamp = (freq != '0) && (el_next < TIMER_WIDTH'(pulse_width));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      freq      <= '0;
      period    <= '0;
      elapsed   <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == B_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            freq <= q_entry.freq;
            if (q_entry.adjust && (q_entry.freq != '0)) begin
              state <= B_DIV;
            end else begin
              if (q_entry.adjust) begin
                period <= '0;
              end
              state <= B_OUT;
            end
          end
        end
        B_DIV: begin
          if (bit_idx == '0) begin
            state <= B_SAT;
          end
        end
        B_SAT: begin
          period <= (CMP_W'(quot) > TMAX_CMP) ? TMAX : TIMER_WIDTH'(quot);
          state  <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            active  <= active_next;
            elapsed <= el_next;
            state   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem     <= '0;
      quot    <= '0;
      bit_idx <= BIT_W'(NUM_W - 1);
    end else if (state == B_DIV) begin
      rem     <= ge ? FREQ_W'(rem_sh - {1'b0, freq}) : rem_sh[FREQ_W-1:0];
      quot    <= {quot[NUM_W-2:0], ge};
      bit_idx <= bit_idx - 1'b1;
    end
    if ((state == B_OUT) && out_free) begin
      strobe   <= lamp;
      out_freq <= freq;
    end
  end

endmodule

@@ design/encoder_tuned_strobe_pulser.sv @@
// Encoder-tuned strobe pulser.
// Each beat on the slave stream is one microsecond tick carrying the signed
// encoder count; each tick produces exactly one beat on the master stream
// with the lamp level and the current frequency (1/512 Hz units).
// The front end takes a tick, works out the clamped count step and its cube
// in two multiplier stages and updates the frequency when it adjusts it. A
// four-entry queue decouples it from the back end, which recomputes the
// period with a restoring divider (one quotient bit per cycle) whenever the
// frequency has been adjusted to a nonzero value, then advances the pulse
// timer. The front end takes a new tick only once the last one is queued,
// and the back end takes a new entry only once the last result has entered
// the output register. When the receiver stalls, the result waits in the
// output register, the queue fills and s_tready then drops. Reset clears
// the frequency, the reference count and the timers, and loads the register
// defaults. Configuration is written through cfg_we/cfg_index/cfg_data while
// idle; the user must keep to this, as the block itself does not enforce it.
module encoder_tuned_strobe_pulser import esp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((COUNT_WIDTH+7)/8)*8-1:0]    s_tdata,   // encoder_position
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_DATA_W-1:0]               m_tdata,   // strobe_out, frequency_value
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  esp_cfg_t   cfg;
  esp_entry_t push_entry;
  esp_entry_t pop_entry;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_width <= PULSE_WIDTH_RST;
      cfg.holdoff     <= HOLDOFF_RST;
      cfg.max_freq    <= MAX_FREQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_WIDTH: cfg.pulse_width <= cfg_data[PW_W-1:0];
        CFG_HOLDOFF:     cfg.holdoff     <= cfg_data[HOLD_W-1:0];
        CFG_MAX_FREQ:    cfg.max_freq    <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  esp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pos    (s_tdata[COUNT_WIDTH-1:0]),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (q_push),
    .push_entry(push_entry)
  );

  esp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_entry (pop_entry)
  );

  esp_back #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (pop_entry),
    .pop        (q_pop),
    .pulse_width(cfg.pulse_width),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

  // The lamp is never lit while the frequency is zero.
  a_lamp_needs_freq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[FREQ_W:1] == '0)))
    else $error("strobe high at zero frequency");

  // The front end handles one tick at a time.
  a_front_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front end accepted a tick while busy");

  // The queue is never written while full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full || q_pop)
    else $error("queue overflow");

  // A beat is only popped when one is stored.
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue underflow");

endmodule
